FILE: hdl/absolute_deadline_timer_queue_core_macros.svh
// ----------------------------------------------------------------------------
// absolute deadline timer queue assertion macros
// concurrent assertion helpers used by the core rtl file
// ----------------------------------------------------------------------------
`ifndef ABSOLUTE_DEADLINE_TIMER_QUEUE_CORE_MACROS_SVH
`define ABSOLUTE_DEADLINE_TIMER_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ADTQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ADTQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ADTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ADTQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define ADTQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ADTQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/adtq_pkg.sv
// ----------------------------------------------------------------------------
// adtq_pkg
// shared types, constants and helpers of the deadline timer queue
// ----------------------------------------------------------------------------
package adtq_pkg;

   localparam int NUM_TIMERS_DEF = 16;

   localparam logic [15:0] EARLY_MARGIN_RST   = 16'd50;
   localparam logic [15:0] PAST_DUE_DELAY_RST = 16'd3000;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic {
      REG_EARLY_MARGIN   = 1'b0,
      REG_PAST_DUE_DELAY = 1'b1
   } reg_sel_type;

   typedef enum logic [1:0] {
      REQ_SET   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   localparam logic KIND_FIRED  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [15:0] early_margin;
      logic [15:0] past_due_delay;
   } cfg_type;

   // sign of the wrapping difference
   function automatic logic is_past(input logic [31:0] t, input logic [31:0] now);
      logic [31:0] diff;
      diff = t - now;
      return diff[31];
   endfunction

endpackage

FILE: hdl/adtq_if.sv
// ----------------------------------------------------------------------------
// adtq channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface adtq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  timer_id;
   logic [31:0] deadline;
   logic [31:0] now;

   modport source (output valid, req_type, timer_id, deadline, now, input ready);
   modport sink   (input valid, req_type, timer_id, deadline, now, output ready);
endinterface

interface adtq_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  fired_timer;
   logic [31:0] compare_time;
   logic        compare_enabled;
   logic        last;

   modport source (output valid, kind, fired_timer, compare_time, compare_enabled, last,
                   input ready);
   modport sink   (input valid, kind, fired_timer, compare_time, compare_enabled, last,
                   output ready);
endinterface

FILE: hdl/adtq_csr.sv
// ----------------------------------------------------------------------------
// adtq_csr
// apb register file holding early margin and past due delay
// ----------------------------------------------------------------------------
module adtq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [adtq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output adtq_pkg::cfg_type                cfg
);
   import adtq_pkg::*;

   cfg_type     cfg_ff;
   logic        wr_en;
   reg_sel_type sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sel        = reg_sel_type'(csr_paddr[2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.early_margin   <= EARLY_MARGIN_RST;
         cfg_ff.past_due_delay <= PAST_DUE_DELAY_RST;
      end else if (wr_en) begin
         case (sel)
            REG_EARLY_MARGIN:   cfg_ff.early_margin   <= csr_pwdata[15:0];
            REG_PAST_DUE_DELAY: cfg_ff.past_due_delay <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_EARLY_MARGIN:   csr_prdata = {16'd0, cfg_ff.early_margin};
         REG_PAST_DUE_DELAY: csr_prdata = {16'd0, cfg_ff.past_due_delay};
         default:            csr_prdata = 32'd0;
      endcase
   end

endmodule

FILE: hdl/absolute_deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// absolute_deadline_timer_queue_core
// sorted queue of wraparound deadline timers kept in two small memories
// ----------------------------------------------------------------------------
//  channel   direction  handshake            content
//  req_if    in         valid/ready          req_type, timer_id, deadline, now
//  rsp_if    out        valid/ready          kind, fired_timer, compare_time,
//                                            compare_enabled, last
//  csr_*     in         apb write/read       early_margin, past_due_delay
//
//  one item at a time; ready is high only while the sequencer is idle
//  unlink walks the order memory in S_UNL_RD, S_UNL_CHK per entry, insert in
//  S_INS_RD, S_INS_OD, S_INS_CHK per entry scanned, S_SH_RD, S_SH_WR per shift,
//  status read in S_STAT_RD, S_STAT_OD, S_STAT_CHK plus output; a tick costs
//  one unlink walk per fired timer; synchronous reset empties the queue at once,
//  no clearing pass; a stalled rsp_if holds the sequencer in its output state
// ----------------------------------------------------------------------------
`include "absolute_deadline_timer_queue_core_macros.svh"

module absolute_deadline_timer_queue_core #(
   parameter int NUM_TIMERS = adtq_pkg::NUM_TIMERS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   adtq_req_if.sink                         req_if,
   adtq_rsp_if.source                       rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [adtq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import adtq_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_UNL_RD, S_UNL_CHK, S_INS_RD, S_INS_OD, S_INS_CHK,
      S_SH_RD, S_SH_WR, S_TICK_RD, S_TICK_OD, S_TICK_CHK, S_TICK_EMIT,
      S_STAT_RD, S_STAT_OD, S_STAT_CHK, S_STAT_EMIT
   } state_type;

   cfg_type cfg;

   adtq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic [31:0]      dl_mem  [NUM_TIMERS];
   logic [IDX_W-1:0] ord_mem [NUM_TIMERS];

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [NUM_TIMERS-1:0] armed_ff;
   logic [1:0]       op_ff;
   logic [IDX_W-1:0] id_ff;
   logic [IDX_W-1:0] i_ff;
   logic [IDX_W-1:0] pos_ff;
   logic             found_ff;
   logic [31:0]      now_ff;
   logic [31:0]      dnew_ff;
   logic [31:0]      ctime_ff;
   logic [IDX_W-1:0] ord_rdata_ff;
   logic [31:0]      dl_rdata_ff;

   logic             out_valid_ff;
   logic             out_kind_ff;
   logic [3:0]       out_fired_ff;
   logic [31:0]      out_ctime_ff;
   logic             out_en_ff;
   logic             out_last_ff;

   logic [31:0]      dl_in;
   logic             id_ok;
   logic [IDX_W-1:0] idx_in;
   logic             front_due;
   logic             out_free;
   logic [IDX_W-1:0] ord_raddr;
   logic             last_slot;

   assign req_if.ready = (state_ff == S_IDLE);

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.kind            = out_kind_ff;
   assign rsp_if.fired_timer     = out_fired_ff;
   assign rsp_if.compare_time    = out_ctime_ff;
   assign rsp_if.compare_enabled = out_en_ff;
   assign rsp_if.last            = out_last_ff;

   always_comb begin
      dl_in = is_past(req_if.deadline, req_if.now) ?
              req_if.now + {16'd0, cfg.past_due_delay} : req_if.deadline;
      id_ok     = ({28'd0, req_if.timer_id} < 32'(NUM_TIMERS));
      idx_in    = IDX_W'(req_if.timer_id);
      front_due = is_past(dl_rdata_ff - {16'd0, cfg.early_margin}, now_ff) ||
                  is_past(dl_rdata_ff, now_ff);
      out_free  = !out_valid_ff || rsp_if.ready;
      last_slot = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);
      case (state_ff)
         S_UNL_RD, S_INS_RD: ord_raddr = i_ff;
         S_SH_RD:            ord_raddr = i_ff - IDX_W'(1);
         default:            ord_raddr = '0;
      endcase
   end

   // synchronous read ports
   always_ff @(posedge clock) begin
      ord_rdata_ff <= ord_mem[ord_raddr];
      dl_rdata_ff  <= dl_mem[ord_rdata_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         armed_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_if.ready &&
             !(out_free && (state_ff == S_TICK_EMIT || state_ff == S_STAT_EMIT)))
            out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  op_ff    <= req_if.req_type;
                  id_ff    <= idx_in;
                  now_ff   <= req_if.now;
                  dnew_ff  <= dl_in;
                  i_ff     <= '0;
                  found_ff <= 1'b0;
                  if (req_if.req_type == REQ_SET && id_ok) begin
                     dl_mem[idx_in]   <= dl_in;
                     armed_ff[idx_in] <= 1'b1;
                     state_ff <= armed_ff[idx_in] ? S_UNL_RD : S_INS_RD;
                  end else if (req_if.req_type == REQ_CLEAR && id_ok && armed_ff[idx_in]) begin
                     armed_ff[idx_in] <= 1'b0;
                     state_ff <= S_UNL_RD;
                  end else if (req_if.req_type == REQ_TICK) begin
                     state_ff <= S_TICK_RD;
                  end else begin
                     state_ff <= S_STAT_RD;
                  end
               end
            end
            S_UNL_RD: state_ff <= S_UNL_CHK;
            S_UNL_CHK: begin
               if (found_ff) ord_mem[i_ff - IDX_W'(1)] <= ord_rdata_ff;
               else if (ord_rdata_ff == id_ff) found_ff <= 1'b1;
               if (last_slot) begin
                  count_ff <= count_ff - CNT_W'(1);
                  i_ff     <= '0;
                  case (op_ff)
                     REQ_SET:  state_ff <= S_INS_RD;
                     REQ_TICK: state_ff <= S_TICK_RD;
                     default:  state_ff <= S_STAT_RD;
                  endcase
               end else begin
                  i_ff     <= i_ff + IDX_W'(1);
                  state_ff <= S_UNL_RD;
               end
            end
            S_INS_RD: begin
               if (CNT_W'(i_ff) == count_ff) begin
                  pos_ff   <= i_ff;
                  state_ff <= S_SH_RD;
               end else begin
                  state_ff <= S_INS_OD;
               end
            end
            S_INS_OD: state_ff <= S_INS_CHK;
            S_INS_CHK: begin
               if (is_past(dnew_ff, dl_rdata_ff)) begin
                  pos_ff   <= i_ff;
                  i_ff     <= IDX_W'(count_ff);
                  state_ff <= S_SH_RD;
               end else begin
                  i_ff     <= i_ff + IDX_W'(1);
                  state_ff <= S_INS_RD;
               end
            end
            S_SH_RD: begin
               if (i_ff == pos_ff) begin
                  ord_mem[pos_ff] <= id_ff;
                  count_ff        <= count_ff + CNT_W'(1);
                  state_ff        <= S_STAT_RD;
               end else begin
                  state_ff <= S_SH_WR;
               end
            end
            S_SH_WR: begin
               ord_mem[i_ff] <= ord_rdata_ff;
               i_ff          <= i_ff - IDX_W'(1);
               state_ff      <= S_SH_RD;
            end
            S_TICK_RD: state_ff <= (count_ff == '0) ? S_STAT_RD : S_TICK_OD;
            S_TICK_OD: state_ff <= S_TICK_CHK;
            S_TICK_CHK: begin
               if (front_due) begin
                  id_ff    <= ord_rdata_ff;
                  state_ff <= S_TICK_EMIT;
               end else begin
                  ctime_ff <= dl_rdata_ff;
                  state_ff <= S_STAT_EMIT;
               end
            end
            S_TICK_EMIT: begin
               if (out_free) begin
                  out_valid_ff    <= 1'b1;
                  out_kind_ff     <= KIND_FIRED;
                  out_fired_ff    <= 4'(id_ff);
                  out_ctime_ff    <= '0;
                  out_en_ff       <= 1'b0;
                  out_last_ff     <= 1'b0;
                  armed_ff[id_ff] <= 1'b0;
                  i_ff            <= '0;
                  found_ff        <= 1'b0;
                  state_ff        <= S_UNL_RD;
               end
            end
            S_STAT_RD: begin
               if (count_ff == '0) begin
                  ctime_ff <= '0;
                  state_ff <= S_STAT_EMIT;
               end else begin
                  state_ff <= S_STAT_OD;
               end
            end
            S_STAT_OD: state_ff <= S_STAT_CHK;
            S_STAT_CHK: begin
               ctime_ff <= dl_rdata_ff;
               state_ff <= S_STAT_EMIT;
            end
            S_STAT_EMIT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= KIND_STATUS;
                  out_fired_ff <= '0;
                  out_ctime_ff <= ctime_ff;
                  out_en_ff    <= (count_ff != '0);
                  out_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ADTQ_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(NUM_TIMERS))
   `ADTQ_ASSERT_IMPLY(a_count_armed, clock, reset, state_ff == S_IDLE, $countones(armed_ff) == int'(count_ff))
   `ADTQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   `ADTQ_ASSERT_IMPLY(a_status_last, clock, reset, out_valid_ff, out_last_ff == out_kind_ff)

endmodule

FILE: test/adtq_checker.sv
// ----------------------------------------------------------------------------
// adtq_checker
// watches the request, response and csr ports of the deadline timer queue,
// keeps its own sorted timer list to work out every response item, and
// compares each accepted response item with the oldest one still owed
// ----------------------------------------------------------------------------
module adtq_checker
   import adtq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   adtq_req_if                   req_mon,
   adtq_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    error_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = NUM_TIMERS_DEF;

   typedef struct {
      logic        kind;
      logic [3:0]  fired_timer;
      logic [31:0] compare_time;
      logic        compare_enabled;
      logic        last;
   } rsp_item_type;

   rsp_item_type owed_rsp[$];
   logic [15:0] margin_q;
   logic [15:0] delay_q;
   logic [31:0] deadline_q[NT];
   logic [3:0]  order_q[NT];
   logic        armed_q[NT];
   int          live_count;

   assign pending_count = owed_rsp.size();

   initial error_count = 0;

   task automatic report(input string msg);
      $display("adtq_checker: %0t %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic wrap_past(input logic [31:0] t, input logic [31:0] now);
      logic [31:0] diff;
      diff = t - now;
      return diff[31];
   endfunction

   function automatic void drop_at(input int pos);
      for (int i = pos; i + 1 < live_count; i++) order_q[i] = order_q[i + 1];
      live_count--;
   endfunction

   function automatic void unlink_timer(input logic [3:0] id);
      for (int i = 0; i < live_count; i++) begin
         if (order_q[i] == id) begin
            drop_at(i);
            return;
         end
      end
   endfunction

   function automatic void insert_timer(input logic [3:0] id);
      int pos;
      pos = 0;
      while (pos < live_count && !wrap_past(deadline_q[id], deadline_q[order_q[pos]]))
         pos++;
      if (live_count >= NT) return;
      for (int i = live_count; i > pos; i--) order_q[i] = order_q[i - 1];
      order_q[pos] = id;
      live_count++;
   endfunction

   function automatic void owe(input logic k, input logic [3:0] f, input logic [31:0] ct,
                               input logic ce, input logic l);
      rsp_item_type r;
      r.kind = k;
      r.fired_timer = f;
      r.compare_time = ct;
      r.compare_enabled = ce;
      r.last = l;
      owed_rsp.push_back(r);
   endfunction

   function automatic void schedule_request(input logic [1:0] rt, input logic [3:0] id,
                                            input logic [31:0] dl, input logic [31:0] now);
      logic [3:0]  f;
      logic [31:0] d;
      case (rt)
         REQ_SET: begin
            if (wrap_past(dl, now)) dl = now + {16'd0, delay_q};
            if (armed_q[id]) unlink_timer(id);
            deadline_q[id] = dl;
            armed_q[id] = 1'b1;
            insert_timer(id);
         end
         REQ_CLEAR: begin
            if (armed_q[id]) begin
               unlink_timer(id);
               armed_q[id] = 1'b0;
            end
         end
         REQ_TICK: begin
            while (live_count > 0) begin
               f = order_q[0];
               d = deadline_q[f];
               if (!wrap_past(d - {16'd0, margin_q}, now) && !wrap_past(d, now)) break;
               drop_at(0);
               armed_q[f] = 1'b0;
               owe(KIND_FIRED, f, 32'd0, 1'b0, 1'b0);
            end
         end
         default: ;
      endcase
      if (live_count > 0) owe(KIND_STATUS, 4'd0, deadline_q[order_q[0]], 1'b1, 1'b1);
      else owe(KIND_STATUS, 4'd0, 32'd0, 1'b0, 1'b1);
   endfunction

   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         margin_q   = EARLY_MARGIN_RST;
         delay_q    = PAST_DUE_DELAY_RST;
         live_count = 0;
         for (int i = 0; i < NT; i++) armed_q[i] = 1'b0;
         owed_rsp.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (reg_sel_type'(csr_paddr[2]) == REG_EARLY_MARGIN) margin_q = csr_pwdata[15:0];
            else delay_q = csr_pwdata[15:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_rsp.size() == 0) begin
               report("response item with nothing owed");
            end else begin
               e = owed_rsp.pop_front();
               if (rsp_mon.kind !== e.kind || rsp_mon.fired_timer !== e.fired_timer ||
                   rsp_mon.compare_time !== e.compare_time ||
                   rsp_mon.compare_enabled !== e.compare_enabled || rsp_mon.last !== e.last)
                  report($sformatf("mismatch got %b/%h/%h/%b/%b want %b/%h/%h/%b/%b",
                     rsp_mon.kind, rsp_mon.fired_timer, rsp_mon.compare_time,
                     rsp_mon.compare_enabled, rsp_mon.last, e.kind, e.fired_timer,
                     e.compare_time, e.compare_enabled, e.last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            schedule_request(req_mon.req_type, req_mon.timer_id, req_mon.deadline,
                             req_mon.now);
      end
   end

endmodule

FILE: test/tb_absolute_deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// tb_absolute_deadline_timer_queue_core
// drives set, clear, tick and nop requests with a moving wraparound time base
// through several early margin and past due delay settings, with random
// stalls on both channels and one long response hold-off
// ----------------------------------------------------------------------------
module tb_absolute_deadline_timer_queue_core;
   import adtq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    pending_count;
   int                    cycles;
   logic                  steady;
   logic                  hold_off_req;
   logic [31:0]           now_t;

   adtq_req_if req_if ();
   adtq_rsp_if rsp_if ();

   absolute_deadline_timer_queue_core uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   adtq_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_absolute_deadline_timer_queue_core: errors");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int held;
      rsp_if.ready <= 1'b0;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req && held == 0) begin
            rsp_if.ready <= 1'b0;
            for (int i = 0; i < 400; i++) @(posedge clock);
            held = 1;
         end
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 29);
      end
   end

   task automatic send(input req_kind_type rt, input logic [3:0] id,
                       input logic [31:0] dl, input logic [31:0] now);
      if (!steady && $urandom_range(0, 99) < 29) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= rt;
      req_if.timer_id <= id;
      req_if.deadline <= dl;
      req_if.now      <= now;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   task automatic csr_write(input reg_sel_type r, input logic [15:0] value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic random_requests(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         now_t = now_t + $urandom_range(0, 120);
         if (pick < 40)
            send(REQ_SET, 4'($urandom_range(0, 15)), now_t + $urandom_range(0, 3000), now_t);
         else if (pick < 50)
            send(REQ_SET, 4'($urandom_range(0, 15)), $urandom, now_t);
         else if (pick < 65)
            send(REQ_CLEAR, 4'($urandom_range(0, 15)), $urandom, now_t);
         else if (pick < 92) begin
            now_t = now_t + $urandom_range(0, 1500);
            send(REQ_TICK, 4'($urandom_range(0, 15)), $urandom, now_t);
         end else if (pick < 96)
            send(REQ_NOP, 4'($urandom_range(0, 15)), $urandom, now_t);
         else begin
            now_t = $urandom;
            send(req_kind_type'(2'($urandom_range(0, 3))), 4'($urandom_range(0, 15)),
                 $urandom, now_t);
         end
      end
   endtask

   initial begin
      reset        <= 1'b1;
      steady       <= 1'b0;
      hold_off_req <= 1'b0;
      req_if.valid <= 1'b0;
      req_if.req_type <= REQ_NOP;
      req_if.timer_id <= 4'd0;
      req_if.deadline <= 32'd0;
      req_if.now      <= 32'd0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, wrap edges, rearm, clear, full queue, multi-fire
      now_t = 32'hFFFF_FF00;
      send(REQ_SET, 4'd15, 32'hFFFF_FFFF, now_t);
      send(REQ_SET, 4'd0, 32'd0, now_t);
      send(REQ_SET, 4'd1, 32'h7FFF_0000, now_t);
      send(REQ_SET, 4'd2, 32'd0, now_t);
      send(REQ_SET, 4'd15, 32'h0000_0100, now_t);
      send(REQ_CLEAR, 4'd7, 32'hFFFF_FFFF, now_t);
      send(REQ_CLEAR, 4'd1, 32'd0, now_t);
      send(REQ_NOP, 4'd9, 32'hA5A5_A5A5, now_t);
      send(REQ_TICK, 4'd0, 32'd0, 32'h0000_0000);
      send(REQ_TICK, 4'd0, 32'd0, 32'h0000_0C00);
      now_t = 32'h0000_1000;
      for (int i = 0; i < 16; i++) send(REQ_SET, 4'(i), now_t + 32'd100, now_t);
      send(REQ_SET, 4'd5, now_t + 32'd100, now_t);
      send(REQ_TICK, 4'd3, 32'hFFFF_FFFF, now_t + 32'd60);

      steady <= 1'b1;
      random_requests(40);
      steady <= 1'b0;
      random_requests(20);

      csr_write(REG_EARLY_MARGIN, 16'd0);
      csr_write(REG_PAST_DUE_DELAY, 16'd0);
      random_requests(20);
      hold_off_req <= 1'b1;
      random_requests(30);

      csr_write(REG_EARLY_MARGIN, 16'hFFFF);
      csr_write(REG_PAST_DUE_DELAY, 16'hFFFF);
      random_requests(55);

      csr_write(REG_EARLY_MARGIN, 16'($urandom_range(0, 2000)));
      csr_write(REG_PAST_DUE_DELAY, 16'($urandom_range(0, 5000)));
      random_requests(45);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (error_count == 0)
         $display("tb_absolute_deadline_timer_queue_core: clean");
      else
         $display("tb_absolute_deadline_timer_queue_core: errors");
      $finish;
   end

endmodule

FILE: absolute_deadline_timer_queue_core.f
+incdir+hdl
hdl/adtq_pkg.sv
hdl/adtq_if.sv
hdl/adtq_csr.sv
hdl/absolute_deadline_timer_queue_core.sv
test/adtq_checker.sv
test/tb_absolute_deadline_timer_queue_core.sv
